FILE: rtl/jsu_pkg.sv
// Types and constants shared by the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_NOOPEN = 2'd2;
  localparam logic [1:0] KIND_UNTERM = 2'd3;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U         = 8'h75;
  localparam logic [7:0] CHAR_QMARK     = 8'h3F;
  localparam logic [15:0] CP_MAX        = 16'h007F;

  localparam logic [1:0] HEX_LAST = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
  } out_item_t;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  hex_count;
    logic [15:0] code_accum;
  } state_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // Letters a..f and A..F share their low nibble: 1..6 maps to 10..15.
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/jsu_step.sv
// Per-beat decode: next parser state and the optional result for one item.
module jsu_step (
  input  jsu_pkg::state_t    cur,
  input  jsu_pkg::in_item_t  item,
  output jsu_pkg::state_t    nxt,
  output jsu_pkg::step_res_t res
);

  logic [7:0]  c;
  logic [15:0] acc;

  assign c   = item.in_byte;
  assign acc = {cur.code_accum[11:0], jsu_pkg::hex_value(c)};

  always_comb begin
    nxt           = cur;
    res.emit      = 1'b0;
    res.item.out_byte = 8'd0;
    res.item.kind = jsu_pkg::KIND_DATA;
    if (item.operation) begin
      nxt.mode       = jsu_pkg::MODE_IDLE;
      nxt.hex_count  = 2'd0;
      nxt.code_accum = 16'd0;
      res.emit       = 1'b1;
      res.item.kind  = (cur.mode == jsu_pkg::MODE_IDLE) ? jsu_pkg::KIND_NOOPEN
                                                        : jsu_pkg::KIND_UNTERM;
    end else begin
      unique case (cur.mode)
        jsu_pkg::MODE_IDLE: begin
          if (c == jsu_pkg::CHAR_QUOTE) begin
            nxt.mode = jsu_pkg::MODE_STR;
          end else begin
            res.emit      = 1'b1;
            res.item.kind = jsu_pkg::KIND_NOOPEN;
          end
        end
        jsu_pkg::MODE_STR: begin
          if (c == jsu_pkg::CHAR_QUOTE) begin
            nxt.mode      = jsu_pkg::MODE_IDLE;
            res.emit      = 1'b1;
            res.item.kind = jsu_pkg::KIND_DONE;
          end else if (c == jsu_pkg::CHAR_BACKSLASH) begin
            nxt.mode = jsu_pkg::MODE_ESC;
          end else begin
            res.emit          = 1'b1;
            res.item.out_byte = c;
          end
        end
        jsu_pkg::MODE_ESC: begin
          if (c == jsu_pkg::CHAR_U) begin
            nxt.mode       = jsu_pkg::MODE_HEX;
            nxt.hex_count  = 2'd0;
            nxt.code_accum = 16'd0;
          end else begin
            nxt.mode          = jsu_pkg::MODE_STR;
            res.emit          = 1'b1;
            res.item.out_byte = jsu_pkg::escape_map(c);
          end
        end
        jsu_pkg::MODE_HEX: begin
          if (cur.hex_count == jsu_pkg::HEX_LAST) begin
            nxt.mode       = jsu_pkg::MODE_STR;
            nxt.hex_count  = 2'd0;
            nxt.code_accum = 16'd0;
            res.emit       = 1'b1;
            // Only codepoints 1..0x7F fit in one byte; anything else becomes '?'.
            if (acc != 16'd0 && acc <= jsu_pkg::CP_MAX) begin
              res.item.out_byte = acc[7:0];
            end else begin
              res.item.out_byte = jsu_pkg::CHAR_QMARK;
            end
          end else begin
            nxt.hex_count  = cur.hex_count + 2'd1;
            nxt.code_accum = acc;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

FILE: rtl/json_string_unescape_top.sv
// Top level of the streaming JSON string unescaper.
// One item is taken per clock cycle while the input side is not stalling.
// Each beat is first held in an input register; from there the parser state
// is updated and any result is written to the output register, which holds
// it while the downstream side stalls. Items that cause no result (opening
// quote, backslash, the u of a hex escape and all but the last hex digit)
// only update the state. The input side stalls only while a result is
// waiting in the output register and the downstream side is stalling.
module json_string_unescape_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_item_t out_data
);

  logic               in_valid_r;
  jsu_pkg::in_item_t  in_data_r;
  jsu_pkg::state_t    state_r;
  jsu_pkg::state_t    state_nxt;
  jsu_pkg::step_res_t res;
  logic               out_valid_r;
  jsu_pkg::out_item_t out_data_r;
  logic               out_free;
  logic               advance;

  jsu_step u_step (
    .cur  (state_r),
    .item (in_data_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode       <= jsu_pkg::MODE_IDLE;
      state_r.hex_count  <= 2'd0;
      state_r.code_accum <= 16'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && res.emit) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/tb_json_string_unescape_top.sv
// Self-checking testbench for the streaming JSON string unescaper.
`timescale 1ns / 100ps

module tb_json_string_unescape_top;
  import jsu_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  json_string_unescape_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_item_t  pending_q[$];
  out_item_t expected_q[$];
  int        errors = 0;
  int        results_seen = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        pattern_kind = 0;
  int        pattern_left = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  // Unescaper state as the testbench tracks it.
  mode_t       str_mode = MODE_IDLE;
  logic [1:0]  hex_taken = '0;
  logic [15:0] code_sum = '0;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] escape_byte(input logic [7:0] c);
    case (c)
      "b":     return 8'h08;
      "f":     return 8'h0C;
      "n":     return 8'h0A;
      "r":     return 8'h0D;
      "t":     return 8'h09;
      default: return c;
    endcase
  endfunction

  // Advances the tracked state by one beat; returns 1 when the beat gives a result.
  function automatic bit unescape_step(input in_item_t beat, output out_item_t res);
    logic [7:0] c;
    c = beat.in_byte;
    res = '0;
    if (beat.operation) begin
      res.kind = (str_mode == MODE_IDLE) ? KIND_NOOPEN : KIND_UNTERM;
      str_mode = MODE_IDLE;
      hex_taken = '0;
      code_sum = '0;
      return 1'b1;
    end
    case (str_mode)
      MODE_IDLE: begin
        if (c == CHAR_QUOTE) begin
          str_mode = MODE_STR;
          return 1'b0;
        end
        res.kind = KIND_NOOPEN;
        return 1'b1;
      end
      MODE_STR: begin
        if (c == CHAR_QUOTE) begin
          str_mode = MODE_IDLE;
          res.kind = KIND_DONE;
          return 1'b1;
        end
        if (c == CHAR_BACKSLASH) begin
          str_mode = MODE_ESC;
          return 1'b0;
        end
        res.out_byte = c;
        res.kind = KIND_DATA;
        return 1'b1;
      end
      MODE_ESC: begin
        if (c == CHAR_U) begin
          str_mode = MODE_HEX;
          hex_taken = '0;
          code_sum = '0;
          return 1'b0;
        end
        str_mode = MODE_STR;
        res.out_byte = escape_byte(c);
        res.kind = KIND_DATA;
        return 1'b1;
      end
      default: begin
        code_sum = {code_sum[11:0], nibble_of(c)};
        if (hex_taken != HEX_LAST) begin
          hex_taken = hex_taken + 2'd1;
          return 1'b0;
        end
        str_mode = MODE_STR;
        hex_taken = '0;
        res.out_byte = (code_sum != 16'd0 && code_sum <= CP_MAX) ? code_sum[7:0] : CHAR_QMARK;
        res.kind = KIND_DATA;
        code_sum = '0;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    in_item_t it;
    it.operation = 1'b0;
    it.in_byte = b;
    pending_q.push_back(it);
  endtask

  // The byte is meaningless with an end mark, so it is randomised to show it is ignored.
  task automatic push_end();
    in_item_t it;
    it.operation = 1'b1;
    it.in_byte = 8'($urandom_range(0, 255));
    pending_q.push_back(it);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  task automatic push_hex_escape(input int digits);
    logic [15:0] cp;
    push_byte(CHAR_BACKSLASH);
    push_byte(CHAR_U);
    cp = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h9F)) : 16'($urandom_range(0, 16'hFFFF));
    for (int i = 3; i >= 4 - digits; i--) begin
      if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
      else push_byte(hex_char(cp[4*i +: 4]));
    end
  endtask

  // One quoted string with random content, mostly well formed.
  task automatic add_random_string();
    string      esc_chars;
    logic [7:0] b;
    int         n;
    int         pick;
    int         ending;
    esc_chars = "bfnrt\"\\/";
    if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
    push_byte(CHAR_QUOTE);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_QUOTE || b == CHAR_BACKSLASH) b = "a";
        push_byte(b);
      end else if (pick < 8) begin
        push_byte(CHAR_BACKSLASH);
        if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)));
        else push_byte(esc_chars[$urandom_range(0, esc_chars.len() - 1)]);
      end else begin
        push_hex_escape(4);
      end
    end
    ending = $urandom_range(0, 19);
    if (ending == 0) begin
      push_end();
    end else if (ending == 1) begin
      push_byte(CHAR_BACKSLASH);
      push_end();
    end else if (ending == 2) begin
      push_hex_escape($urandom_range(0, 3));
      push_end();
    end else begin
      push_byte(CHAR_QUOTE);
      if (ending == 3) push_end();
    end
  endtask

  // Sender: bursts of beats with random gaps; a stalled beat is held unchanged.
  always @(posedge clk) begin : drive_proc
    logic      nv;
    in_item_t  nd;
    out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      nv = in_valid;
      nd = in_data;
      if (in_valid && !in_stall) begin
        if (unescape_step(in_data, res)) expected_q.push_back(res);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          nd = pending_q.pop_front();
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= nv;
      in_data <= nd;
    end
  end

  // A single long hold-off once results are flowing, so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stall pattern changes between free running, light, heavy and near solid.
  always @(posedge clk) begin : stall_proc
    logic ns;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_kind = $urandom_range(0, 3);
        pattern_left = $urandom_range(4, 40);
      end else begin
        pattern_left--;
      end
      case (pattern_kind)
        0:       ns = 1'b0;
        1:       ns = ($urandom_range(0, 3) == 0);
        2:       ns = 1'($urandom_range(0, 1));
        default: ns = ($urandom_range(0, 7) != 0);
      endcase
      if (hold_left > 0) ns = 1'b1;
      out_stall <= ns;
    end
  end

  always @(posedge clk) begin : check_proc
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with nothing expected: byte=%02h kind=%0d",
                   out_data.out_byte, out_data.kind);
      end else begin
        want = expected_q.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.kind !== want.kind) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result %0d: expected byte=%02h kind=%0d, got byte=%02h kind=%0d",
                     results_seen, want.out_byte, want.kind, out_data.out_byte, out_data.kind);
        end
      end
    end
  end

  initial begin
    // Directed part: stray byte and end mark while idle, then a string with
    // extreme bytes, a control escape, hex escapes in and out of range and an
    // unknown escape, then strings cut off after a backslash and mid hex escape.
    push_str("x");
    push_end();
    push_byte(CHAR_QUOTE);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("\\n\\u0041\\ufFfF\\q\"");
    push_str("\"\\");
    push_end();
    push_str("\"\\u7");
    push_end();
    while (pending_q.size() < 1080) add_random_string();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
